FILE: rtl/ultrasonic_range_collision_monitor_defines.svh
// assertion macros for the ultrasonic range collision monitor
// no dependencies; included by modules that carry assertions
`ifndef ULTRASONIC_RANGE_COLLISION_MONITOR_DEFINES_SVH
`define ULTRASONIC_RANGE_COLLISION_MONITOR_DEFINES_SVH

// same-cycle implication
`define URCM_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define URCM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/urcm_pkg.sv
// shared constants, types and register indexes of the range collision monitor
// no dependencies
package urcm_pkg;

   localparam int ECHO_WIDTH_BITS = 16;
   localparam int SINCE_BITS      = 20;
   localparam int TRIG_BITS       = 16;
   localparam int DIST_BITS       = 15;
   localparam int CSR_INDEX_BITS  = 8;
   localparam int CSR_DATA_BITS   = 32;

   localparam int MULT_BITS  = 9;
   localparam int DIST_MULT  = 281;
   localparam int DIST_SHIFT = 10;
   localparam int PROD_BITS  = ECHO_WIDTH_BITS + MULT_BITS;
   localparam int SHIFT_BITS = PROD_BITS - DIST_SHIFT;

   localparam logic [SINCE_BITS-1:0]      SINCE_MAX = '1;
   localparam logic [TRIG_BITS-1:0]       TRIG_MAX  = '1;
   localparam logic [ECHO_WIDTH_BITS-1:0] WIDTH_MAX = '1;
   localparam logic [DIST_BITS-1:0]       DIST_MAX  = '1;

   localparam logic [SINCE_BITS-1:0] INTERVAL_RESET = 20'd100000;
   localparam logic [TRIG_BITS-1:0]  TRIGGER_RESET  = 16'd1000;
   localparam logic [DIST_BITS-1:0]  IMMINENT_RESET = 15'd160;
   localparam logic [DIST_BITS-1:0]  DETECTED_RESET = 15'd800;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_INTERVAL = 8'd0,
      REG_TRIGGER  = 8'd1,
      REG_IMMINENT = 8'd2,
      REG_DETECTED = 8'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      CLASS_NONE     = 2'd0,
      CLASS_DETECTED = 2'd1,
      CLASS_IMMINENT = 2'd2
   } class_type;

   typedef struct packed {
      logic [SINCE_BITS-1:0] interval_ticks;
      logic [TRIG_BITS-1:0]  trigger_ticks;
      logic [DIST_BITS-1:0]  imminent_dist_q4;
      logic [DIST_BITS-1:0]  detected_dist_q4;
   } cfg_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] distance_q4;
      class_type            coll_class;
      logic                 buzzer_on;
   } range_type;

endpackage

FILE: rtl/urcm_if.sv
// handshake channels of the range collision monitor: tick, result and csr write
// depends on urcm_pkg
interface urcm_req_if;
   logic valid;
   logic ready;
   logic echo_level;

   modport source (output valid, output echo_level, input ready);
   modport sink (input valid, input echo_level, output ready);
endinterface

interface urcm_rsp_if import urcm_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic                 trigger_level;
   logic                 buzzer_on;
   class_type            collision_class;
   logic [DIST_BITS-1:0] distance_q4;
   logic                 measure_done;

   modport source (output valid, output trigger_level, output buzzer_on,
                   output collision_class, output distance_q4, output measure_done,
                   input ready);
   modport sink (input valid, input trigger_level, input buzzer_on,
                 input collision_class, input distance_q4, input measure_done,
                 output ready);
endinterface

interface urcm_csr_if import urcm_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] reg_index;
   logic [CSR_DATA_BITS-1:0]  write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

FILE: rtl/urcm_csr.sv
// configuration registers of the range collision monitor
// depends on urcm_pkg and urcm_csr_if
module urcm_csr import urcm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   urcm_csr_if.sink      csr_bus,
   output cfg_type       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.reg_index))
            REG_INTERVAL: cfg_in.interval_ticks   = csr_bus.write_data[SINCE_BITS-1:0];
            REG_TRIGGER:  cfg_in.trigger_ticks    = csr_bus.write_data[TRIG_BITS-1:0];
            REG_IMMINENT: cfg_in.imminent_dist_q4 = csr_bus.write_data[DIST_BITS-1:0];
            REG_DETECTED: cfg_in.detected_dist_q4 = csr_bus.write_data[DIST_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval_ticks   <= INTERVAL_RESET;
         cfg_ff.trigger_ticks    <= TRIGGER_RESET;
         cfg_ff.imminent_dist_q4 <= IMMINENT_RESET;
         cfg_ff.detected_dist_q4 <= DETECTED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/urcm_range.sv
// echo width to distance conversion and collision classification
// depends on urcm_pkg
module urcm_range import urcm_pkg::*; (
   input  logic [ECHO_WIDTH_BITS-1:0] echo_width,
   input  cfg_type                    cfg,
   output range_type                  result
);

   logic [PROD_BITS-1:0]  product;
   logic [SHIFT_BITS-1:0] scaled;
   logic [DIST_BITS-1:0]  distance;

   // width * 281 >> 10, saturated to the field
   assign product = PROD_BITS'(echo_width) * PROD_BITS'(DIST_MULT);
   assign scaled  = product[PROD_BITS-1:DIST_SHIFT];

   always_comb begin
      if (scaled > SHIFT_BITS'(DIST_MAX)) begin
         distance = DIST_MAX;
      end else begin
         distance = DIST_BITS'(scaled);
      end
   end

   always_comb begin
      result.distance_q4 = distance;
      if (distance <= cfg.imminent_dist_q4) begin
         result.coll_class = CLASS_IMMINENT;
         result.buzzer_on  = 1'b1;
      end else if (distance <= cfg.detected_dist_q4) begin
         result.coll_class = CLASS_DETECTED;
         result.buzzer_on  = 1'b1;
      end else begin
         result.coll_class = CLASS_NONE;
         result.buzzer_on  = 1'b0;
      end
   end

endmodule

FILE: rtl/urcm_seq.sv
// tick register, trigger/echo phase sequencer and result register
// depends on urcm_pkg, urcm_req_if, urcm_rsp_if and the defines header
`include "ultrasonic_range_collision_monitor_defines.svh"

module urcm_seq import urcm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   urcm_req_if.sink                   req_bus,
   urcm_rsp_if.source                 rsp_bus,
   input  cfg_type                    cfg,
   input  range_type                  range_result,
   output logic [ECHO_WIDTH_BITS-1:0] echo_width
);

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_TRIG = 2'd1,
      PH_WAIT = 2'd2,
      PH_MEAS = 2'd3
   } phase_type;

   logic                       in_valid_ff, in_valid_in;
   logic                       in_echo_ff;
   phase_type                  phase_ff, phase_in;
   logic [SINCE_BITS-1:0]      since_ff, since_in, since_inc;
   logic [TRIG_BITS-1:0]       tcount_ff, tcount_in, tcount_inc;
   logic [ECHO_WIDTH_BITS-1:0] width_ff, width_in;
   class_type                  class_ff, class_in;
   logic [DIST_BITS-1:0]       dist_ff, dist_in;
   logic                       trigger_ff, trigger_in;
   logic                       buzzer_ff, buzzer_in;
   logic                       done_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_done_ff;
   logic                       advance;
   logic                       req_accept;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_accept   = req_bus.valid && req_bus.ready;
   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_bus.ready);
   assign echo_width   = width_ff;

   assign since_inc  = (since_ff == SINCE_MAX) ? since_ff : since_ff + 1'b1;
   assign tcount_inc = (tcount_ff == TRIG_MAX) ? tcount_ff : tcount_ff + 1'b1;

   always_comb begin
      phase_in   = phase_ff;
      since_in   = since_ff;
      tcount_in  = tcount_ff;
      width_in   = width_ff;
      class_in   = class_ff;
      dist_in    = dist_ff;
      trigger_in = trigger_ff;
      buzzer_in  = buzzer_ff;
      done_in    = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            since_in = since_inc;
            if (since_inc >= cfg.interval_ticks) begin
               trigger_in = 1'b1;
               tcount_in  = '0;
               phase_in   = PH_TRIG;
            end
         end
         PH_TRIG: begin
            tcount_in = tcount_inc;
            if (tcount_inc >= cfg.trigger_ticks) begin
               trigger_in = 1'b0;
               phase_in   = PH_WAIT;
            end
         end
         PH_WAIT: begin
            if (in_echo_ff) begin
               width_in = ECHO_WIDTH_BITS'(1);
               phase_in = PH_MEAS;
            end
         end
         PH_MEAS: begin
            if (in_echo_ff) begin
               if (width_ff != WIDTH_MAX) begin
                  width_in = width_ff + 1'b1;
               end
            end else begin
               dist_in   = range_result.distance_q4;
               class_in  = range_result.coll_class;
               buzzer_in = range_result.buzzer_on;
               since_in  = '0;
               phase_in  = PH_IDLE;
               done_in   = 1'b1;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         since_ff     <= '0;
         tcount_ff    <= '0;
         width_ff     <= '0;
         class_ff     <= CLASS_NONE;
         dist_ff      <= '0;
         trigger_ff   <= 1'b0;
         buzzer_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff   <= phase_in;
            since_ff   <= since_in;
            tcount_ff  <= tcount_in;
            width_ff   <= width_in;
            class_ff   <= class_in;
            dist_ff    <= dist_in;
            trigger_ff <= trigger_in;
            buzzer_ff  <= buzzer_in;
         end
      end
      if (req_accept) begin
         in_echo_ff <= req_bus.echo_level;
      end
      if (advance) begin
         rsp_done_ff <= done_in;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.trigger_level   = trigger_ff;
   assign rsp_bus.buzzer_on       = buzzer_ff;
   assign rsp_bus.collision_class = class_ff;
   assign rsp_bus.distance_q4     = dist_ff;
   assign rsp_bus.measure_done    = rsp_done_ff;

   `URCM_ASSERT_IMPLY(a_trigger_phase, clock, reset, 1'b1, trigger_ff == (phase_ff == PH_TRIG), "trigger level out of step with phase")
   `URCM_ASSERT_IMPLY(a_buzzer_class, clock, reset, 1'b1, buzzer_ff == (class_ff != CLASS_NONE), "buzzer disagrees with class")
   `URCM_ASSERT_NEXT(a_done_idle, clock, reset, advance && done_in, phase_ff == PH_IDLE && since_ff == '0, "completed measurement did not restart interval")
   `URCM_ASSERT_NEXT(a_tick_hold, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_echo_ff), "stalled tick lost")

endmodule

FILE: rtl/ultrasonic_range_collision_monitor.sv
// a tick word is taken into the tick register; its result word is registered
// once the result register is empty or its word is taken; throughput: one word
// per cycle while results are taken, set by the single-pass sequencer update
// the tick register takes a new word while a result word waits to be taken
// reset: synchronous, clears phase, counters, last distance and class, and
// restores the csr defaults
module ultrasonic_range_collision_monitor import urcm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   urcm_req_if.sink   req_bus,
   urcm_rsp_if.source rsp_bus,
   urcm_csr_if.sink   csr_bus
);

   cfg_type                    cfg;
   range_type                  range_result;
   logic [ECHO_WIDTH_BITS-1:0] echo_width;

   urcm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   urcm_range u_range (
      .echo_width (echo_width),
      .cfg        (cfg),
      .result     (range_result)
   );

   urcm_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .cfg          (cfg),
      .range_result (range_result),
      .echo_width   (echo_width)
   );

endmodule
